// ===== design/dsdl_pkg.sv =====
// ----------------------------------------------------------------------------
// dsdl_pkg
// shared constants, types and helpers of the depth sorted draw list
// ----------------------------------------------------------------------------
`default_nettype none

package dsdl_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int ENTRY_W  = KEY_W + HANDLE_W + 1;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_FLUSH = 1'b1
    } t_opcode;

    // stored entry: key low, handle above, kind on top
    typedef struct packed {
        logic                kind;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } t_entry;

    // signed compare of two q16.16 keys: a > b
    function automatic logic key_greater(input logic [KEY_W-1:0] a,
                                         input logic [KEY_W-1:0] b);
        return $signed(a) > $signed(b);
    endfunction

endpackage

`default_nettype wire

// ===== design/dsdl_ram.sv =====
// ----------------------------------------------------------------------------
// dsdl_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module dsdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/depth_sorted_draw_list_top.sv =====
// ----------------------------------------------------------------------------
// depth_sorted_draw_list_top
// stable depth ordered draw list built on an insertion sort over one ram
// ----------------------------------------------------------------------------
// input stream: tuser carries the opcode (push or flush) and the item kind,
// tdata carries the signed q16.16 depth key and the 32-bit handle.
// a push stores one item, kept in sorted order; a push into a full store is
// dropped. a flush emits every stored item, lowest depth first, equal keys in
// push order, with tlast on the final one, and then empties the store. a
// flush of an empty store emits nothing.
// a push moves up every stored item with a larger key, each by a read and a
// write of the one ram port pair, compared in the single key comparator.
// a flush emits the stored items one after another, each by one ram read and
// one output register load; it waits while the receiver is not ready.
// the input is not ready while a push or flush is in progress.
// a stalled receiver holds the output register and the flush waits; a new
// transaction is accepted while the final result still waits to be taken.
// synchronous reset empties the store and clears the output valid; the ram
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_sorted_draw_list_top #(
    parameter int CAPACITY = dsdl_pkg::DEF_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // depth_key, item_handle
    input  wire logic [1:0]  s_axis_tuser,  // opcode, item_kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // out_handle, out_depth
    output logic             m_axis_tuser,  // out_kind
    output logic             m_axis_tlast
);

    import dsdl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_INS,
        S_FRD,
        S_FLD
    } t_state;

    t_state          r_state;
    logic [FW-1:0]   r_fill;
    logic [AW-1:0]   r_pos;
    logic [AW-1:0]   r_k;
    t_entry          r_item;
    logic            r_m_valid;
    t_entry          r_m_entry;
    logic            r_m_last;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_entry          ram_wdata;
    logic [AW-1:0]   ram_raddr;
    t_entry          ram_rdata;
    logic            greater;
    logic            in_xfer;
    logic            out_xfer;
    logic            out_free;
    logic            out_load;
    t_entry          in_entry;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = r_m_valid && m_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign out_load = (r_state == S_FLD) && out_free;

    assign in_entry = {s_axis_tuser[1], s_axis_tdata[63:32], s_axis_tdata[31:0]};

    assign greater = key_greater(ram_rdata.key, r_item.key);

    assign ram_we    = (r_state == S_CMP) || (r_state == S_INS);
    assign ram_waddr = r_pos;
    assign ram_wdata = ((r_state == S_CMP) && greater) ? ram_rdata : r_item;
    assign ram_raddr = ((r_state == S_FRD) || (r_state == S_FLD)) ? r_k
                                                                   : r_pos - AW'(1);

    dsdl_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_pos     <= '0;
            r_k       <= '0;
            r_m_valid <= 1'b0;
            r_m_last  <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (out_xfer) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (t_opcode'(s_axis_tuser[0]) == OP_PUSH) begin
                            r_item <= in_entry;
                            if (r_fill != FW'(CAPACITY)) begin
                                r_pos   <= r_fill[AW-1:0];
                                r_state <= (r_fill == '0) ? S_INS : S_RD;
                            end
                        end else if (r_fill != '0) begin
                            r_k     <= '0;
                            r_state <= S_FRD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (greater) begin
                        r_pos   <= r_pos - AW'(1);
                        r_state <= (r_pos == AW'(1)) ? S_INS : S_RD;
                    end else begin
                        r_fill  <= r_fill + FW'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_INS: begin
                    r_fill  <= r_fill + FW'(1);
                    r_state <= S_IDLE;
                end
                S_FRD: begin
                    r_state <= S_FLD;
                end
                S_FLD: begin
                    if (out_free) begin
                        r_m_entry <= ram_rdata;
                        if (FW'(r_k) + FW'(1) == r_fill) begin
                            r_m_last <= 1'b1;
                            r_fill   <= '0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_m_last <= 1'b0;
                            r_k      <= r_k + AW'(1);
                            r_state  <= S_FRD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_entry.key, r_m_entry.handle};
    assign m_axis_tuser  = r_m_entry.kind;
    assign m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire

// ===== bench/depth_sorted_draw_list_top_tb.sv =====
// ----------------------------------------------------------------------------
// depth_sorted_draw_list_top_tb
// self-checking bench for the depth sorted draw list
// ----------------------------------------------------------------------------
// pushes draw items and flushes the list over the input stream. each flush is
// predicted by a sorted queue: a stable insert on push, drop when full, and a
// drain in ascending signed depth with tlast on the final item. every output
// transaction is compared against the oldest predicted item. covers key
// extremes, equal keys, overflow of the store, empty flushes, long output
// stalls that back up the input, and random idling on both streams.
// ----------------------------------------------------------------------------
module depth_sorted_draw_list_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dsdl_pkg::*;

    localparam int CAPACITY       = DEF_CAPACITY;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic        kind;
        logic [31:0] handle;
        logic [31:0] depth;
        logic        last;
    } t_draw_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;  // depth_key, item_handle
    logic [1:0]  s_axis_tuser = '0;  // opcode, item_kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;       // out_handle, out_depth
    logic        m_axis_tuser;       // out_kind
    logic        m_axis_tlast;

    t_entry       sorted_store[$];
    t_draw_result pending_draws[$];
    int           error_count = 0;
    int           quiet_cycles = 0;
    bit           idle_enable = 1'b1;
    bit           hold_req = 1'b0;
    bit           hold_ack = 1'b0;
    int           rx_stall_left = 0;

    depth_sorted_draw_list_top #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // stable insert: new item goes behind every stored item with an equal key
    function automatic void store_draw(logic [31:0] key, logic kind, logic [31:0] handle);
        t_entry entry;
        int     pos;
        if (sorted_store.size() >= CAPACITY)
            return;
        entry.kind   = kind;
        entry.handle = handle;
        entry.key    = key;
        pos = sorted_store.size();
        while (pos > 0 && $signed(sorted_store[pos-1].key) > $signed(key))
            pos--;
        sorted_store.insert(pos, entry);
    endfunction

    function automatic void release_draws();
        t_draw_result draw;
        for (int k = 0; k < sorted_store.size(); k++) begin
            draw.kind   = sorted_store[k].kind;
            draw.handle = sorted_store[k].handle;
            draw.depth  = sorted_store[k].key;
            draw.last   = (k == sorted_store.size() - 1);
            pending_draws = {pending_draws, draw};
        end
        sorted_store.delete();
    endfunction

    function automatic logic [31:0] pick_depth();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 8)) - 4);
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return {16'($urandom_range(0, 3) - 2), 16'h0000};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(t_opcode op, logic [31:0] key, logic kind, logic [31:0] handle);
        int gap;
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {handle, key};
        s_axis_tuser  <= {kind, op};
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_PUSH)
            store_draw(key, kind, handle);
        else
            release_draws();
    endtask

    task automatic send_push(logic [31:0] key);
        send_item(OP_PUSH, key, 1'($urandom), $urandom);
    endtask

    task automatic send_flush();
        send_item(OP_FLUSH, $urandom, 1'($urandom), $urandom);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_draws.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_flush();
        send_item(OP_PUSH, 32'h7fff_ffff, 1'b1, 32'hffff_ffff);
        send_flush();
        send_item(OP_PUSH, 32'h8000_0000, 1'b0, 32'h0000_0000);
        send_item(OP_PUSH, 32'h7fff_ffff, 1'b1, 32'hffff_ffff);
        send_item(OP_PUSH, 32'h0000_0000, 1'b0, 32'haaaa_aaaa);
        send_item(OP_PUSH, 32'hffff_ffff, 1'b1, 32'h5555_5555);
        send_item(OP_PUSH, 32'h0001_0000, 1'b0, 32'h0000_0001);
        send_item(OP_PUSH, 32'h0000_0001, 1'b1, 32'h8000_0000);
        send_item(OP_PUSH, 32'h0001_0000, 1'b1, 32'h0000_0002);
        send_item(OP_PUSH, 32'hffff_0000, 1'b0, 32'h7fff_ffff);
        send_item(OP_PUSH, 32'h0001_0000, 1'b0, 32'h0000_0003);
        send_item(OP_PUSH, 32'h8000_0000, 1'b1, 32'h1234_5678);
        send_item(OP_FLUSH, 32'hffff_ffff, 1'b1, 32'hffff_ffff);
        send_flush();
        wait_drained();
    endtask

    // descending keys make each of the first CAPACITY/2 pushes shift the whole store
    task automatic test_store_overflow();
        logic [31:0] key;
        key = 32'h4000_0000;
        for (int i = 0; i < CAPACITY + 3; i++) begin
            if (i < CAPACITY / 2) begin
                key = key - $urandom_range(1, 1 << 20);
                send_push(key);
            end else begin
                send_push(pick_depth());
            end
        end
        send_flush();
        wait_drained();
    endtask

    // output held off while a flush and further pushes queue up behind it
    task automatic test_output_stall();
        for (int i = 0; i < 12; i++)
            send_push(pick_depth());
        hold_req = ~hold_req;
        send_flush();
        for (int i = 0; i < 8; i++)
            send_push(pick_depth());
        send_flush();
        wait_drained();
    endtask

    task automatic test_random_mix(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 11) == 0)
                send_flush();
            else
                send_push(pick_depth());
        end
        send_flush();
    endtask

    task automatic test_full_rate(int count);
        idle_enable = 1'b0;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 7) == 0)
                send_flush();
            else
                send_push(pick_depth());
        end
        send_flush();
    endtask

    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            rx_stall_left = RX_HOLD_CYCLES;
        end
        if (rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left--;
        end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left = $urandom_range(0, 15);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_draw_result exp_draw;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_draws.size() == 0) begin
                $error("result with none expected: handle %h depth %h",
                       m_axis_tdata[31:0], m_axis_tdata[63:32]);
                error_count++;
            end else begin
                exp_draw = pending_draws.pop_front();
                if (m_axis_tuser !== exp_draw.kind) begin
                    $error("out_kind expected %0d actual %0d", exp_draw.kind, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[31:0] !== exp_draw.handle) begin
                    $error("out_handle expected %h actual %h",
                           exp_draw.handle, m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tdata[63:32] !== exp_draw.depth) begin
                    $error("out_depth expected %0d actual %0d",
                           $signed(exp_draw.depth), $signed(m_axis_tdata[63:32]));
                    error_count++;
                end
                if (m_axis_tlast !== exp_draw.last) begin
                    $error("last_item expected %0d actual %0d", exp_draw.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_store_overflow();
        test_output_stall();
        test_random_mix(100);
        test_full_rate(30);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (pending_draws.size() != 0) begin
            $error("%0d expected results never arrived", pending_draws.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== depth_sorted_draw_list_top.f =====
design/dsdl_pkg.sv
design/dsdl_ram.sv
design/depth_sorted_draw_list_top.sv
bench/depth_sorted_draw_list_top_tb.sv
